// ===== rtl/core/pcs_pkg.sv =====
// shared types, constants and register codes of the piecewise contrast stretch
`default_nettype none

package pcs_pkg;

  localparam int unsigned PcsPixW         = 8;
  localparam int unsigned PcsProdW        = 2 * PcsPixW;
  localparam int unsigned PcsQuotBits     = PcsPixW;
  localparam int unsigned PcsStepsPerStage = 2;
  localparam int unsigned PcsDivStages    = PcsQuotBits / PcsStepsPerStage;
  // segment select, multiply, divide stages, final add
  localparam int unsigned PcsStages       = PcsDivStages + 3;
  localparam int unsigned PcsCfgIdxW      = 2;

  typedef logic [PcsPixW-1:0] pixel_t;

  localparam pixel_t PcsFullScale = pixel_t'(255);

  // reset values of the breakpoints
  localparam pixel_t PcsRstInLow   = pixel_t'(70);
  localparam pixel_t PcsRstInHigh  = pixel_t'(180);
  localparam pixel_t PcsRstOutLow  = pixel_t'(30);
  localparam pixel_t PcsRstOutHigh = pixel_t'(220);

  typedef enum logic [PcsCfgIdxW-1:0] {
    RegInBreakLow   = 2'd0,
    RegInBreakHigh  = 2'd1,
    RegOutBreakLow  = 2'd2,
    RegOutBreakHigh = 2'd3
  } pcs_reg_e;

  // breakpoints as seen by the datapath
  typedef struct packed {
    pixel_t in_low;
    pixel_t in_high;
    pixel_t out_low;
    pixel_t out_high;
  } pcs_cfg_t;

  // one pixel in flight through the divider
  typedef struct packed {
    pixel_t rem;      // partial remainder
    pixel_t low;      // dividend bits still to consume, quotient bits shifted in
    pixel_t divisor;
    logic   neg;      // negate the quotient
    pixel_t offset;   // level added after the division
  } pcs_work_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcs_stream_if.sv =====
// valid/ready stream interfaces for input and output pixels
`default_nettype none

interface pcs_in_if;
  logic            valid;
  logic            ready;
  pcs_pkg::pixel_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pcs_out_if;
  logic            valid;
  logic            ready;
  pcs_pkg::pixel_t pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/piecewise_contrast_stretch_top.sv =====
// top level of the piecewise linear contrast stretch pipeline
//
// Maps each 8-bit gray pixel through a three-segment linear curve set by the
// breakpoints (in_break_low, out_break_low) and (in_break_high, out_break_high).
// Pixels enter on pix_in_i and leave on pix_out_o, both valid/ready streams;
// a transfer happens when valid and ready are both high.
// Breakpoints are written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one
// register per cycle. The user must write them only while no pixel is in
// flight; the block itself does not enforce this. The pipeline has 7
// register stages: segment select, 8x8 multiply, four divider stages of two
// quotient bits each, final add.
// Throughput is one pixel per cycle while the output is not stalled; the
// multiplier and each divider stage take a new pixel every cycle.
// Reset empties the pipeline and loads the breakpoints 70, 180, 30 and 220.
// When the receiver stalls, each stage holds until the one after it frees up,
// so empty stages still fill and input keeps being taken until the pipeline
// is full; nothing is dropped or repeated.
`default_nettype none

module piecewise_contrast_stretch_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  pcs_in_if.sink                               pix_in_i,
  pcs_out_if.source                            pix_out_o,
  input  logic                                 cfg_we_i,
  input  logic [pcs_pkg::PcsCfgIdxW-1:0]       cfg_idx_i,
  input  pcs_pkg::pixel_t                      cfg_wdata_i
);
  import pcs_pkg::*;

  localparam int unsigned LastStage = PcsStages - 1;

  pcs_cfg_t  cfg_q;
  pcs_reg_e  cfg_idx;

  logic [PcsStages-1:0] valid_q, valid_d;
  logic [PcsStages-1:0] adv;

  pcs_work_t div_work [PcsDivStages+1];
  pcs_work_t fin;
  pixel_t    quot;
  pixel_t    pixel_out_d, pixel_out_q;

  // breakpoint registers
  assign cfg_idx = pcs_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_low   <= PcsRstInLow;
      cfg_q.in_high  <= PcsRstInHigh;
      cfg_q.out_low  <= PcsRstOutLow;
      cfg_q.out_high <= PcsRstOutHigh;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        RegInBreakLow:   cfg_q.in_low   <= cfg_wdata_i;
        RegInBreakHigh:  cfg_q.in_high  <= cfg_wdata_i;
        RegOutBreakLow:  cfg_q.out_low  <= cfg_wdata_i;
        RegOutBreakHigh: cfg_q.out_high <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[LastStage] = !valid_q[LastStage] || pix_out_o.ready;
    for (int k = int'(LastStage) - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign valid_d = {valid_q[PcsStages-2:0], pix_in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int unsigned k = 0; k < PcsStages; k++) begin
        if (adv[k]) valid_q[k] <= valid_d[k];
      end
    end
  end

  assign pix_in_i.ready = adv[0];

  // segment select and multiply
  pcs_front u_front (
    .clk_i    (clk_i),
    .en_sel_i (adv[0]),
    .en_mul_i (adv[1]),
    .pixel_i  (pix_in_i.pixel_in),
    .cfg_i    (cfg_q),
    .work_o   (div_work[0])
  );

  // divider stages
  for (genvar g = 0; g < PcsDivStages; g++) begin : g_div
    pcs_div_stage u_div (
      .clk_i  (clk_i),
      .en_i   (adv[g+2]),
      .work_i (div_work[g]),
      .work_o (div_work[g+1])
    );
  end

  // apply sign and add the segment offset
  assign fin         = div_work[PcsDivStages];
  assign quot        = fin.low;
  assign pixel_out_d = fin.neg ? (fin.offset - quot) : (fin.offset + quot);

  always_ff @(posedge clk_i) begin
    if (adv[LastStage]) begin
      pixel_out_q <= pixel_out_d;
    end
  end

  assign pix_out_o.valid     = valid_q[LastStage];
  assign pix_out_o.pixel_out = pixel_out_q;

  // an empty output register never holds back the input
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_out_o.valid |-> pix_in_i.ready)
    else $error("input stalled while output stage empty");

  // the stage before the output stage keeps its pixel while stalled
  a_stall_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[LastStage-1] && !adv[LastStage-1]) |=> valid_q[LastStage-1])
    else $error("pixel lost in stalled stage");

  // the divider never sees a zero divisor
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (div_work[0].divisor != '0))
    else $error("zero divisor entered the divider");

  // the division ends with a remainder below the divisor
  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LastStage-1] |-> (fin.rem < fin.divisor))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ===== rtl/core/pcs_front.sv =====
// segment select stage and multiply stage feeding the divider
`default_nettype none

module pcs_front (
  input  logic               clk_i,
  input  logic               en_sel_i,
  input  logic               en_mul_i,
  input  pcs_pkg::pixel_t    pixel_i,
  input  pcs_pkg::pcs_cfg_t  cfg_i,
  output pcs_pkg::pcs_work_t work_o
);
  import pcs_pkg::*;

  pixel_t fac_a_d, fac_a_q;
  pixel_t fac_b_d, fac_b_q;
  pixel_t div_d, div_q;
  logic   neg_d, neg_q;
  pixel_t off_d, off_q;

  logic [PcsProdW-1:0] prod;
  pcs_work_t           work_d, work_q;

  // pick the segment and its factors, divisor and offset
  always_comb begin
    fac_a_d = '0;
    fac_b_d = '0;
    div_d   = pixel_t'(1);
    neg_d   = 1'b0;
    off_d   = '0;
    priority if (pixel_i < cfg_i.in_low) begin
      fac_a_d = cfg_i.out_low;
      fac_b_d = pixel_i;
      div_d   = cfg_i.in_low;
    end else if (pixel_i <= cfg_i.in_high) begin
      off_d = cfg_i.out_low;
      if (cfg_i.in_high != cfg_i.in_low) begin
        neg_d   = cfg_i.out_high < cfg_i.out_low;
        fac_a_d = neg_d ? (cfg_i.out_low - cfg_i.out_high)
                        : (cfg_i.out_high - cfg_i.out_low);
        fac_b_d = pixel_i - cfg_i.in_low;
        div_d   = cfg_i.in_high - cfg_i.in_low;
      end
    end else begin
      fac_a_d = PcsFullScale - cfg_i.out_high;
      fac_b_d = pixel_i - cfg_i.in_high;
      div_d   = PcsFullScale - cfg_i.in_high;
      off_d   = cfg_i.out_high;
    end
  end

  // select stage registers
  always_ff @(posedge clk_i) begin
    if (en_sel_i) begin
      fac_a_q <= fac_a_d;
      fac_b_q <= fac_b_d;
      div_q   <= div_d;
      neg_q   <= neg_d;
      off_q   <= off_d;
    end
  end

  // product magnitude, split into starting remainder and low dividend bits
  assign prod = PcsProdW'(fac_a_q) * PcsProdW'(fac_b_q);

  always_comb begin
    work_d.rem     = prod[PcsProdW-1:PcsPixW];
    work_d.low     = prod[PcsPixW-1:0];
    work_d.divisor = div_q;
    work_d.neg     = neg_q;
    work_d.offset  = off_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      work_q <= work_d;
    end
  end

  assign work_o = work_q;

endmodule

`default_nettype wire

// ===== rtl/core/pcs_div_stage.sv =====
// one divider stage: PcsStepsPerStage restoring-division steps, then a register
`default_nettype none

module pcs_div_stage (
  input  logic               clk_i,
  input  logic               en_i,
  input  pcs_pkg::pcs_work_t work_i,
  output pcs_pkg::pcs_work_t work_o
);
  import pcs_pkg::*;

  pcs_work_t          work_d, work_q;
  logic [PcsPixW:0]   trial;

  // shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    work_d = work_i;
    trial  = '0;
    for (int unsigned s = 0; s < PcsStepsPerStage; s++) begin
      trial = {work_d.rem, work_d.low[PcsPixW-1]};
      if (trial >= {1'b0, work_d.divisor}) begin
        work_d.rem = PcsPixW'(trial - {1'b0, work_d.divisor});
        work_d.low = {work_d.low[PcsPixW-2:0], 1'b1};
      end else begin
        work_d.rem = trial[PcsPixW-1:0];
        work_d.low = {work_d.low[PcsPixW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign work_o = work_q;

endmodule

`default_nettype wire
